### rtl/core/smsa_pkg.sv
package smsa_pkg;

  // Histogram geometry: one bin per sample value.
  localparam int unsigned VALUE_BINS = 256;
  localparam int unsigned BIN_W      = $clog2(VALUE_BINS);
  localparam int unsigned CNT_W      = 11;

  // Window geometry.
  localparam int unsigned MAX_WINDOW = 1024;
  localparam int unsigned POS_W      = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W      = 11;

  // Result fields.
  localparam int unsigned TM_W        = BIN_W + 1;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // Access to the histogram memory.
  typedef struct packed {
    logic             clr;
    logic             re;
    logic [BIN_W-1:0] raddr;
    logic             we;
    logic [BIN_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
  } hist_req_t;

  // Access to the sample ring memory.
  typedef struct packed {
    logic             re;
    logic [POS_W-1:0] raddr;
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [BIN_W-1:0] wdata;
  } ring_req_t;

endpackage

### rtl/core/smsa_hist_store.sv
module smsa_hist_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  smsa_pkg::hist_req_t         req,
  output logic [smsa_pkg::CNT_W-1:0]  rdata
);

  logic [smsa_pkg::CNT_W-1:0]      mem_r [smsa_pkg::VALUE_BINS];
  logic [smsa_pkg::VALUE_BINS-1:0] vld_r;
  logic [smsa_pkg::CNT_W-1:0]      rd_r;
  logic                            rd_vld_r;

  // Count storage with a registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r     <= mem_r[req.raddr];
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  // One valid bit per bin; a bin never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

### rtl/core/smsa_ring_store.sv
module smsa_ring_store (
  input  logic                        clk,
  input  smsa_pkg::ring_req_t         req,
  output logic [smsa_pkg::BIN_W-1:0]  rdata
);

  logic [smsa_pkg::BIN_W-1:0] mem_r [smsa_pkg::MAX_WINDOW];
  logic [smsa_pkg::BIN_W-1:0] rd_r;

  // Sample ring with a registered read port; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rd_r;

endmodule

### rtl/core/smsa_ctrl.sv
module smsa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [smsa_pkg::LEN_W-1:0]        win_len,
  input  logic                              cfg_clr,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [smsa_pkg::BIN_W-1:0]        in_sample,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smsa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output smsa_pkg::hist_req_t               hist_req,
  input  logic [smsa_pkg::CNT_W-1:0]        hist_rdata,
  output smsa_pkg::ring_req_t               ring_req,
  input  logic [smsa_pkg::BIN_W-1:0]        ring_rdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DEC_RD = 7'b0000100,
    ST_DEC_WR = 7'b0001000,
    ST_INC_RD = 7'b0010000,
    ST_INC_WR = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  localparam logic [smsa_pkg::BIN_W-1:0] LAST_BIN = smsa_pkg::BIN_W'(smsa_pkg::VALUE_BINS - 1);

  state_t                           state_r, state_nxt;
  logic [smsa_pkg::BIN_W-1:0]       sample_r, sample_nxt;
  logic                             fill_mode_r, fill_mode_nxt;
  logic [smsa_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [smsa_pkg::LEN_W-1:0]       fill_r, fill_nxt;
  logic [smsa_pkg::TOTAL_W-1:0]     cnt_r, cnt_nxt;
  logic [smsa_pkg::LEN_W:0]         cum_r, cum_nxt;
  logic [smsa_pkg::BIN_W-1:0]       iss_bin_r, iss_bin_nxt;
  logic                             iss_more_r, iss_more_nxt;
  logic                             prc_vld_r, prc_vld_nxt;
  logic [smsa_pkg::BIN_W-1:0]       prc_bin_r, prc_bin_nxt;
  logic                             phase_b_r, phase_b_nxt;
  logic [smsa_pkg::BIN_W-1:0]       lo_r, lo_nxt;
  logic [smsa_pkg::TM_W-1:0]        tm_r, tm_nxt;
  logic                             alert_r, alert_nxt;
  logic                             out_vld_r, out_vld_nxt;
  logic [smsa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [smsa_pkg::LEN_W:0]         cum_sum;
  logic [smsa_pkg::LEN_W:0]         half;
  logic                             even_len;
  logic [smsa_pkg::LEN_W:0]         pos_inc;
  logic                             scan_done;
  logic [smsa_pkg::TM_W-1:0]        scan_tm;
  logic                             scan_alert;

  assign half     = {2'b00, win_len[smsa_pkg::LEN_W-1:1]};
  assign even_len = ~win_len[0];
  assign cum_sum  = cum_r + {1'b0, hist_rdata};
  assign pos_inc  = {2'b00, pos_r} + 12'd1;

  // Scan step: consumes the count of the bin read in the previous cycle.
  always_comb begin
    scan_done   = 1'b0;
    scan_tm     = '0;
    phase_b_nxt = phase_b_r;
    lo_nxt      = lo_r;
    cum_nxt     = cum_r;
    if (state_r == ST_SCAN && prc_vld_r) begin
      if (!phase_b_r) begin
        cum_nxt = cum_sum;
        if (cum_sum > half) begin
          scan_done = 1'b1;
          scan_tm   = {prc_bin_r, 1'b0};
        end else if (even_len && cum_sum == half && cum_sum != '0) begin
          phase_b_nxt = 1'b1;
          lo_nxt      = prc_bin_r;
          if (prc_bin_r == LAST_BIN) begin
            scan_done = 1'b1;
            scan_tm   = {prc_bin_r, 1'b0};
          end
        end else if (prc_bin_r == LAST_BIN) begin
          scan_done = 1'b1;
          scan_tm   = '0;
        end
      end else begin
        // Looking for the next occupied bin above the lower middle value.
        if (hist_rdata != '0) begin
          scan_done = 1'b1;
          scan_tm   = {1'b0, lo_r} + {1'b0, prc_bin_r};
        end else if (prc_bin_r == LAST_BIN) begin
          scan_done = 1'b1;
          scan_tm   = {lo_r, 1'b0};
        end
      end
    end
    scan_alert = ({1'b0, sample_r} >= scan_tm);
  end

  // Sequencer and memory accesses.
  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    fill_mode_nxt = fill_mode_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    iss_bin_nxt   = iss_bin_r;
    iss_more_nxt  = iss_more_r;
    prc_vld_nxt   = 1'b0;
    prc_bin_nxt   = prc_bin_r;
    tm_nxt        = tm_r;
    alert_nxt     = alert_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    hist_req      = '0;
    ring_req      = '0;
    hist_req.clr  = cfg_clr;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_sample;
          if (fill_r < win_len) begin
            fill_mode_nxt = 1'b1;
            state_nxt     = ST_INC_RD;
          end else begin
            fill_mode_nxt = 1'b0;
            ring_req.re   = 1'b1;
            ring_req.raddr = pos_r;
            iss_bin_nxt   = '0;
            iss_more_nxt  = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_more_r) begin
          hist_req.re    = 1'b1;
          hist_req.raddr = iss_bin_r;
          prc_vld_nxt    = 1'b1;
          prc_bin_nxt    = iss_bin_r;
          iss_bin_nxt    = iss_bin_r + 1'b1;
          iss_more_nxt   = (iss_bin_r != LAST_BIN);
        end
        if (scan_done) begin
          prc_vld_nxt = 1'b0;
          tm_nxt      = scan_tm;
          alert_nxt   = scan_alert;
          if (scan_alert && cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = ST_DEC_RD;
        end
      end
      ST_DEC_RD: begin
        hist_req.re    = 1'b1;
        hist_req.raddr = ring_rdata;
        state_nxt      = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        // Remove the oldest sample from its bin.
        hist_req.we    = (hist_rdata != '0);
        hist_req.waddr = ring_rdata;
        hist_req.wdata = hist_rdata - 1'b1;
        state_nxt      = ST_INC_RD;
      end
      ST_INC_RD: begin
        hist_req.re    = 1'b1;
        hist_req.raddr = sample_r;
        state_nxt      = ST_INC_WR;
      end
      ST_INC_WR: begin
        // Add the new sample to its bin and to the ring.
        hist_req.we    = 1'b1;
        hist_req.waddr = sample_r;
        hist_req.wdata = hist_rdata + 1'b1;
        ring_req.we    = 1'b1;
        ring_req.waddr = pos_r;
        ring_req.wdata = sample_r;
        pos_nxt = (pos_inc >= {1'b0, win_len}) ? '0 : pos_inc[smsa_pkg::POS_W-1:0];
        if (fill_mode_r) begin
          fill_nxt  = fill_r + 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {6'b0, cnt_r, tm_r, alert_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new window length restarts the fill.
    if (cfg_clr) begin
      pos_nxt  = '0;
      fill_nxt = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      fill_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      prc_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      prc_vld_r <= prc_vld_nxt;
    end
  end

  // Payload and scan working registers.
  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    fill_mode_r <= fill_mode_nxt;
    iss_bin_r   <= iss_bin_nxt;
    iss_more_r  <= iss_more_nxt;
    prc_bin_r   <= prc_bin_nxt;
    tm_r        <= tm_nxt;
    alert_r     <= alert_nxt;
    out_data_r  <= out_data_nxt;
    if (state_r == ST_IDLE) begin
      cum_r     <= '0;
      phase_b_r <= 1'b0;
      lo_r      <= '0;
    end else begin
      cum_r     <= cum_nxt;
      phase_b_r <= phase_b_nxt;
      lo_r      <= lo_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/sliding_median_spike_alert.sv
// Channel  | Direction | Payload (lowest bit first)
// in_      | in        | tdata[7:0] sample
// out_     | out       | tdata[0] alert, [9:1] twice_median, [41:10] alert_total, [47:42] zero
// cfg_     | in        | wr_data[10:0] window_length, taken when wr_en is high
//
// An item is accepted first. While the window fills, its bin is then read and written
// back. Once it is full, the median search reads one histogram bin per cycle, then the
// oldest sample is swapped for the new one (DEC_RD, DEC_WR, INC_RD, INC_WR) and the
// output register is loaded. Reset and a window_length write clear the histogram at
// once through per-bin valid bits. A finished result waits in the output register while
// the next item is taken; the sequencer only stalls if a second result is ready first.
module sliding_median_spike_alert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,  // window_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata     // alert, twice_median, alert_total, zero fill
);

  logic [smsa_pkg::LEN_W-1:0] win_len_r, win_len_nxt;
  logic [smsa_pkg::LEN_W-1:0] eff_len;
  smsa_pkg::hist_req_t        hist_req;
  smsa_pkg::ring_req_t        ring_req;
  logic [smsa_pkg::CNT_W-1:0] hist_rdata;
  logic [smsa_pkg::BIN_W-1:0] ring_rdata;

  // Window length register.
  assign win_len_nxt = cfg_wr_en ? cfg_wr_data : win_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= smsa_pkg::LEN_W'(1);
    end else begin
      win_len_r <= win_len_nxt;
    end
  end

  // Zero acts as one; lengths above the ring size saturate.
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = smsa_pkg::LEN_W'(1);
    end else if (win_len_r > smsa_pkg::LEN_W'(smsa_pkg::MAX_WINDOW)) begin
      eff_len = smsa_pkg::LEN_W'(smsa_pkg::MAX_WINDOW);
    end else begin
      eff_len = win_len_r;
    end
  end

  smsa_hist_store u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rdata (hist_rdata)
  );

  smsa_ring_store u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  smsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_len    (eff_len),
    .cfg_clr    (cfg_wr_en),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_sample  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .hist_req   (hist_req),
    .hist_rdata (hist_rdata),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata)
  );

endmodule

### rtl/core/smsa_checker.sv
module smsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An accepted item drops in_tready and keeps it low while the block works on the item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("item accepted while previous item still in work");

  // The doubled median never exceeds twice the top bin.
  a_tm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:1] != 9'h1FF)
    else $error("twice_median out of range");

  // Fill bits above the fields stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:42] == 6'b0)
    else $error("nonzero fill bits in result");

  // A result never rises directly after an item is accepted.
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared directly after accept");

endmodule

bind sliding_median_spike_alert smsa_checker u_smsa_checker (.*);

### sim/testbench.sv
module testbench;

  // One result item of the block, in the order the fields sit in out_tdata.
  typedef struct packed {
    logic                         alert;
    logic [smsa_pkg::TM_W-1:0]    twice_median;
    logic [smsa_pkg::TOTAL_W-1:0] alert_total;
  } spike_report_t;

  // How the samples of one phase are spread over the value range.
  typedef enum int unsigned {
    STYLE_SPREAD,
    STYLE_CLUSTER,
    STYLE_TWO_LEVEL,
    STYLE_SPIKY
  } sample_style_t;

  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned LONG_HOLD       = 3000;
  localparam int unsigned RANDOM_ITEMS    = 750;
  localparam int unsigned FILL_ONLY_ITEMS = 40;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             cfg_wr_en   = 1'b0;
  logic [smsa_pkg::LEN_W-1:0]       cfg_wr_data = '0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [smsa_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [smsa_pkg::OUT_TDATA_W-1:0] out_tdata;

  sliding_median_spike_alert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Shadow copy of the window, the histogram and the alert count.
  int unsigned                  bin_count [smsa_pkg::VALUE_BINS];
  logic [smsa_pkg::BIN_W-1:0]   win_samples [smsa_pkg::MAX_WINDOW];
  int unsigned                  win_wr_pos;
  int unsigned                  fill_level;
  int unsigned                  win_len_setting;
  logic [smsa_pkg::TOTAL_W-1:0] alert_tally;
  spike_report_t                alert_reports_due [$];

  // Sender and receiver bookkeeping.
  logic [smsa_pkg::IN_TDATA_W-1:0] sample_queue [$];
  int unsigned   samples_queued_total = 0;
  int unsigned   samples_taken_total  = 0;
  bit            sample_taken = 1'b0;
  int unsigned   tx_gap = 0;
  int unsigned   rx_hold = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            long_hold_req = 1'b0;
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;

  // Shape of the samples in the current phase.
  sample_style_t sample_style = STYLE_SPREAD;
  logic [7:0]    style_lo = '0;
  logic [7:0]    style_hi = '0;

  // A zero length acts as one, and lengths past the ring are cut to its size.
  function automatic int unsigned span_of(int unsigned setting);
    if (setting == 0) return 1;
    if (setting > smsa_pkg::MAX_WINDOW) return smsa_pkg::MAX_WINDOW;
    return setting;
  endfunction

  function automatic void clear_window_model();
    foreach (bin_count[i]) bin_count[i] = 0;
    win_wr_pos = 0;
    fill_level = 0;
  endfunction

  // Walks the cumulative histogram; an even window sums the two middle values.
  function automatic int unsigned doubled_window_median(int unsigned span);
    int unsigned half;
    int unsigned cum;
    half = span / 2;
    cum = 0;
    for (int j = 0; j < smsa_pkg::VALUE_BINS; j++) begin
      cum += bin_count[j];
      if (cum > half) return 2 * j;
      if (span % 2 == 0 && cum == half && cum != 0) begin
        for (int k = j + 1; k < smsa_pkg::VALUE_BINS; k++)
          if (bin_count[k] != 0) return j + k;
        return 2 * j;
      end
    end
    return 0;
  endfunction

  function automatic void enter_sample(logic [7:0] s, int unsigned span);
    win_samples[win_wr_pos] = s;
    bin_count[s]++;
    win_wr_pos = (win_wr_pos + 1 >= span) ? 0 : win_wr_pos + 1;
  endfunction

  // Updates the shadow state for one accepted item and queues its result, if any.
  function automatic void median_alert_step(logic [7:0] s);
    int unsigned   span;
    int unsigned   tm;
    logic [7:0]    oldest;
    spike_report_t rep;
    span = span_of(win_len_setting);
    if (fill_level < span) begin
      enter_sample(s, span);
      fill_level++;
      return;
    end
    tm = doubled_window_median(span);
    rep.alert = (s >= tm);
    if (rep.alert && alert_tally != '1) alert_tally++;
    oldest = win_samples[win_wr_pos];
    if (bin_count[oldest] != 0) bin_count[oldest]--;
    enter_sample(s, span);
    rep.twice_median = tm[smsa_pkg::TM_W-1:0];
    rep.alert_total = alert_tally;
    alert_reports_due.push_back(rep);
  endfunction

  function automatic void check_field(string name, logic [smsa_pkg::TOTAL_W-1:0] want,
                                      logic [smsa_pkg::TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [7:0] pick_sample();
    int v;
    case (sample_style)
      STYLE_SPREAD: begin
        return 8'($urandom_range(0, 255));
      end
      STYLE_CLUSTER: begin
        v = int'(style_lo) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
      end
      STYLE_TWO_LEVEL: begin
        return $urandom_range(0, 1) ? style_hi : style_lo;
      end
      default: begin
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
                                           : 8'($urandom_range(0, 40));
      end
    endcase
  endfunction

  task automatic offer(input logic [7:0] s);
    sample_queue.push_back(s);
    samples_queued_total++;
  endtask

  task automatic queue_samples(input int unsigned n);
    repeat (n) offer(pick_sample());
  endtask

  task automatic wait_drained();
    while (samples_taken_total != samples_queued_total || alert_reports_due.size() != 0)
      @(posedge clk);
  endtask

  // Writes the window length once the block has gone idle.
  task automatic write_window(input logic [smsa_pkg::LEN_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_len_setting = value;
    clear_window_model();
  endtask

  task automatic pick_phase_shape();
    sample_style = sample_style_t'($urandom_range(0, 3));
    style_lo = 8'($urandom_range(0, 255));
    style_hi = 8'($urandom_range(0, 255));
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // Sender: presents the next pending item at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || sample_taken) begin
      sample_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_tdata <= sample_queue.pop_front();
        in_tvalid <= 1'b1;
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random, and once for a long stretch on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_hold = rx_idle_on ? pick_gap() : 0;
    end
  end

  // Both handshakes are taken at the rising edge: predict on input, check on output.
  always @(posedge clk) begin : handshakes
    spike_report_t want;
    if (rst_n && in_tvalid && in_tready) begin
      median_alert_step(in_tdata);
      sample_taken = 1'b1;
      samples_taken_total++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (alert_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = alert_reports_due.pop_front();
        check_field("alert", smsa_pkg::TOTAL_W'(want.alert),
                    smsa_pkg::TOTAL_W'(out_tdata[0]));
        check_field("twice_median", smsa_pkg::TOTAL_W'(want.twice_median),
                    smsa_pkg::TOTAL_W'(out_tdata[9:1]));
        check_field("alert_total", want.alert_total, out_tdata[41:10]);
        check_field("zero fill", '0, smsa_pkg::TOTAL_W'(out_tdata[47:42]));
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned planned;
    int unsigned extra;
    int unsigned r;
    int unsigned phase_items;
    logic [smsa_pkg::LEN_W-1:0] len_value;
    bit first_random;

    win_len_setting = 1;
    alert_tally = '0;
    clear_window_model();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Window of one after reset: extremes, equality and a spike over the previous sample.
    offer(8'd0);   offer(8'd255); offer(8'd0);   offer(8'd255); offer(8'd128);
    offer(8'd255); offer(8'd127); offer(8'd254); offer(8'd85);  offer(8'd170);

    // A zero length acts as a window of one.
    write_window(11'd0);
    offer(8'd7); offer(8'd200); offer(8'd3);

    // Even window: the doubled median is the sum of the two middle values.
    write_window(11'd2);
    offer(8'd10); offer(8'd30); offer(8'd30); offer(8'd10);
    offer(8'd200); offer(8'd0); offer(8'd255);

    // Largest window, and a length above the ring that is cut back to it; both stay filling.
    pick_phase_shape();
    write_window(11'(smsa_pkg::MAX_WINDOW));
    queue_samples(FILL_ONLY_ITEMS);
    pick_phase_shape();
    write_window(11'h7FF);
    queue_samples(FILL_ONLY_ITEMS);

    // Random phases, each with its own length and sample shape.
    planned = 20 + 2 * FILL_ONLY_ITEMS;
    first_random = 1'b1;
    while (planned < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (first_random) len_value = 11'd3;
      else if (r < 10) len_value = 11'd1;
      else if (r < 14) len_value = 11'd0;
      else if (r < 80) len_value = 11'($urandom_range(2, 16));
      else len_value = 11'($urandom_range(17, 96));
      extra = first_random ? 40 : $urandom_range(5, 40);
      phase_items = span_of(len_value) + extra;
      pick_phase_shape();
      write_window(len_value);
      queue_samples(phase_items);
      // Hold the receiver off long enough for the block to back up into its input.
      if (first_random) long_hold_req = 1'b1;
      first_random = 1'b0;
      planned += phase_items;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
rtl/core/smsa_pkg.sv
rtl/core/smsa_hist_store.sv
rtl/core/smsa_ring_store.sv
rtl/core/smsa_ctrl.sv
rtl/core/sliding_median_spike_alert.sv
rtl/core/smsa_checker.sv
sim/testbench.sv
